### rtl/core/incremental_prime_generator_macros.svh
// Assertion macros used by the prime generator top level.
`ifndef INCREMENTAL_PRIME_GENERATOR_MACROS_SVH
`define INCREMENTAL_PRIME_GENERATOR_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define IPG_ASSERT_HOLDS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define IPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ipg_pkg.sv
// Shared types and constants of the prime generator.
package ipg_pkg;

  // Default geometry
  localparam int MaxPrimesDefault     = 256;
  localparam int CandidateBitsDefault = 20;

  // Fixed field widths
  localparam int CountW = 17;

  // Seeds and reset values
  localparam int FirstCandidate = 2;
  localparam int SeedPrime      = 2;
  localparam int SeedMultiple   = 4;
  localparam int LimitReset     = 1000;

  // Control part of the token that travels down the cell row
  typedef struct packed {
    logic valid;  // token present in this stage
    logic hit;    // candidate matched a pending multiple upstream
    logic ins;    // candidate still wants a table slot if prime
  } tok_ctl_t;

endpackage

### rtl/core/ipg_in_if.sv
// Input channel of the prime generator: one restart flag per transaction.
interface ipg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

### rtl/core/ipg_out_if.sv
// Output channel of the prime generator: one result per transaction.
interface ipg_out_if import ipg_pkg::*; #(
  parameter int CandidateBits = CandidateBitsDefault,
  parameter int CountBits     = CountW
);
  logic                     valid;
  logic                     ready;
  logic [CandidateBits-1:0] candidate;
  logic                     is_prime;
  logic [CountBits-1:0]     prime_count;
  logic                     done_res;
  logic                     table_overflow;

  modport source (output valid, output candidate, output is_prime, output prime_count,
                  output done_res, output table_overflow, input ready);
  modport sink   (input valid, input candidate, input is_prime, input prime_count,
                  input done_res, input table_overflow, output ready);
endinterface

### rtl/core/incremental_prime_generator.sv
// Each candidate is squared, then a token walks the row of MaxPrimes sieve cells one cell per
// cycle and the result is registered; a candidate past the limit skips the row. One candidate
// is in flight at a time: a new transaction is taken only after the result has gone into the
// output register, which waits while the result channel still holds an unaccepted result.
// Reset (rst_ni low, asynchronous): limit 1000, table holds 2 with multiple 4,
// next candidate 2, counts and overflow cleared; restart re-seeds all but the limit.
module incremental_prime_generator import ipg_pkg::*; #(
  parameter int MaxPrimes     = MaxPrimesDefault,
  parameter int CandidateBits = CandidateBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upper_limit_we_i,
  input  logic [CandidateBits-1:0] upper_limit_i,
  ipg_in_if.sink                   in_i,
  ipg_out_if.source                out_o
);

  `include "incremental_prime_generator_macros.svh"

  localparam int CW = CandidateBits;

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  localparam logic [CW:0] CandStart = (CW + 1)'(FirstCandidate);

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     limit_q;
  logic [CW:0]       next_cand_q;
  logic [CW:0]       cand_q;
  logic [2*CW-1:0]   sq_q;
  logic              done_q;
  logic              hit_q;
  logic              need_q;
  logic [CountW-1:0] found_q;
  logic              overflow_q;

  logic              out_valid_q;
  logic [CW-1:0]     out_cand_q;
  logic              out_prime_q;
  logic [CountW-1:0] out_count_q;
  logic              out_done_q;
  logic              out_ovf_q;

  logic              in_fire;
  logic              init;
  logic              slot_free;
  logic              is_prime;
  logic [CountW-1:0] found_d;
  logic              overflow_d;

  tok_ctl_t          chain_ctl  [MaxPrimes+1];
  logic [CW-1:0]     chain_cand [MaxPrimes+1];
  logic [CW-1:0]     chain_sq   [MaxPrimes+1];

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign init       = in_fire && in_i.restart;
  assign slot_free  = !out_valid_q || out_o.ready;

  // Hold the limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CW'(LimitReset);
    end else if (upper_limit_we_i) begin
      limit_q <= upper_limit_i;
    end
  end

  // Sequence one candidate: square, walk the row unless past the limit, deliver
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = S_SQUARE;
      S_SQUARE: state_d = (cand_q > {1'b0, limit_q}) ? S_FIN : S_LAUNCH;
      S_LAUNCH: state_d = S_RUN;
      S_RUN:    if (chain_ctl[MaxPrimes].valid) state_d = S_FIN;
      S_FIN:    if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Work out the outcome and the updated counters
  assign is_prime   = !done_q && !hit_q;
  assign found_d    = (is_prime && (found_q != {CountW{1'b1}})) ? found_q + 1'b1 : found_q;
  assign overflow_d = overflow_q || (is_prime && need_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_cand_q <= CandStart;
      found_q     <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (init) begin
        next_cand_q <= CandStart;
        found_q     <= '0;
        overflow_q  <= 1'b0;
      end
      if (state_q == S_FIN && slot_free) begin
        found_q     <= found_d;
        overflow_q  <= overflow_d;
        if (!done_q) next_cand_q <= cand_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the candidate in flight
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cand_q <= in_i.restart ? CandStart : next_cand_q;
    end
    if (state_q == S_SQUARE) begin
      sq_q   <= {{CW{1'b0}}, cand_q[CW-1:0]} * {{CW{1'b0}}, cand_q[CW-1:0]};
      done_q <= (cand_q > {1'b0, limit_q});
    end
    if (state_q == S_RUN && chain_ctl[MaxPrimes].valid) begin
      hit_q  <= chain_ctl[MaxPrimes].hit;
      need_q <= chain_ctl[MaxPrimes].ins;
    end
    if (state_q == S_FIN && slot_free) begin
      out_cand_q  <= cand_q[CW-1:0];
      out_prime_q <= is_prime;
      out_count_q <= found_d;
      out_done_q  <= done_q;
      out_ovf_q   <= overflow_d;
    end
  end

  // Launch the token into the first cell
  always_comb begin
    chain_ctl[0].valid = (state_q == S_LAUNCH);
    chain_ctl[0].hit   = 1'b0;
    chain_ctl[0].ins   = (cand_q != CandStart) && (sq_q <= {{CW{1'b0}}, limit_q});
  end
  assign chain_cand[0] = cand_q[CW-1:0];
  assign chain_sq[0]   = sq_q[CW-1:0];

  // Row of sieve cells
  for (genvar k = 0; k < MaxPrimes; k++) begin : g_cell
    ipg_cell #(
      .CandidateBits (CW),
      .First         (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .init_i (init),
      .ctl_i  (chain_ctl[k]),
      .cand_i (chain_cand[k]),
      .sq_i   (chain_sq[k]),
      .ctl_o  (chain_ctl[k+1]),
      .cand_o (chain_cand[k+1]),
      .sq_o   (chain_sq[k+1])
    );
  end

  // Drive the result channel
  assign out_o.valid          = out_valid_q;
  assign out_o.candidate      = out_cand_q;
  assign out_o.is_prime       = out_prime_q;
  assign out_o.prime_count    = out_count_q;
  assign out_o.done_res       = out_done_q;
  assign out_o.table_overflow = out_ovf_q;

  // Checks
  `IPG_ASSERT_HOLDS(a_tok_only_in_run, clk_i, rst_ni, !chain_ctl[MaxPrimes].valid || (state_q == S_RUN), "token left the row outside the run phase")
  `IPG_ASSERT_HOLDS(a_done_not_prime, clk_i, rst_ni, !(out_o.valid && out_o.done_res && out_o.is_prime), "candidate past the limit reported prime")
  `IPG_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni, overflow_q && !init, overflow_q, "overflow flag dropped without restart")

endmodule

### rtl/core/ipg_cell.sv
// One sieve cell: holds a prime and its pending multiple, passes the token on.
module ipg_cell import ipg_pkg::*; #(
  parameter int CandidateBits = CandidateBitsDefault,
  parameter bit First         = 1'b0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     init_i,
  input  tok_ctl_t                 ctl_i,
  input  logic [CandidateBits-1:0] cand_i,
  input  logic [CandidateBits-1:0] sq_i,
  output tok_ctl_t                 ctl_o,
  output logic [CandidateBits-1:0] cand_o,
  output logic [CandidateBits-1:0] sq_o
);

  localparam logic [CandidateBits-1:0] PrimeSeed = CandidateBits'(SeedPrime);
  localparam logic [CandidateBits:0]   MultSeed  = (CandidateBits + 1)'(SeedMultiple);

  logic                     valid_q, valid_d;
  logic [CandidateBits-1:0] prime_q, prime_d;
  logic [CandidateBits:0]   mult_q, mult_d;
  tok_ctl_t                 ctl_q, ctl_d;
  logic [CandidateBits-1:0] cand_q, sq_q;

  logic match, take;

  // Compare the passing candidate with this cell's multiple
  assign match = ctl_i.valid && valid_q && (mult_q == {1'b0, cand_i});
  // Claim the first free slot for a prime that needs storing
  assign take  = ctl_i.valid && !valid_q && !ctl_i.hit && ctl_i.ins;

  always_comb begin
    valid_d = valid_q;
    prime_d = prime_q;
    mult_d  = mult_q;
    if (init_i) begin
      valid_d = First;
      prime_d = First ? PrimeSeed : '0;
      mult_d  = First ? MultSeed : '0;
    end else if (match) begin
      mult_d = mult_q + {1'b0, prime_q};
    end else if (take) begin
      valid_d = 1'b1;
      prime_d = cand_i;
      mult_d  = {1'b0, sq_i};
    end
  end

  // Advance the token, folding in this cell's outcome
  always_comb begin
    ctl_d       = ctl_i;
    ctl_d.valid = ctl_i.valid && !init_i;
    ctl_d.hit   = ctl_i.hit || match;
    ctl_d.ins   = ctl_i.ins && !take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= First;
      prime_q <= First ? PrimeSeed : '0;
      mult_q  <= First ? MultSeed : '0;
      ctl_q   <= '0;
    end else begin
      valid_q <= valid_d;
      prime_q <= prime_d;
      mult_q  <= mult_d;
      ctl_q   <= ctl_d;
    end
  end

  // Token payload needs no reset
  always_ff @(posedge clk_i) begin
    cand_q <= cand_i;
    sq_q   <= sq_i;
  end

  assign ctl_o  = ctl_q;
  assign cand_o = cand_q;
  assign sq_o   = sq_q;

endmodule
